// ===== hw/rtl/obds_pkg.sv =====
`default_nettype none
package obds_pkg;
	localparam int MaxDepthDefault = 32;
	localparam int PriceW = 20;
	localparam int VolInW = 16;
	localparam int VolW = 32;
	localparam int DepthW = 6;
	localparam int QueueDepth = 4;

	typedef struct packed {
		logic is_sell;
		logic [PriceW-1:0] price;
		logic [VolInW-1:0] volume;
		logic final_order;
	} in_item_t;

	typedef struct packed {
		logic out_is_sell;
		logic [PriceW-1:0] level_price;
		logic [VolW-1:0] level_volume;
		logic last_level;
	} out_item_t;
endpackage
`default_nettype wire

// ===== hw/rtl/order_book_depth_snapshot_core.sv =====
`default_nettype none
// Aggregated top-of-book snapshot engine.
// Orders enter through a queue-style port: an item is taken when push is
// high and full is low. A four-entry queue decouples intake from the book.
// Each book side is a sorted insertion chain that places one order per cycle,
// merging equal prices with saturating volume sums.
// The order marked final triggers a dump of up to depth sell levels in
// descending price, then up to depth buy levels in descending price.
// The dump emits one level per cycle unless the reader stalls; after the final
// order is taken, a setup state latches the level counts before the dump.
// Order intake from the queue pauses until the last level is loaded into the
// output register; the queue keeps taking up to four orders meanwhile.
// Results are read queue-style: the item is valid while empty is low and
// taken when pop is high; a stalled reader freezes the dump.
// A snapshot with no levels emits nothing but still clears both books.
// Reset empties the queue and both books and sets depth to one.
// Users must write depth via cfg_we/cfg_data only while idle (not enforced).
module order_book_depth_snapshot_core import obds_pkg::*; #(
	parameter int MaxDepth = MaxDepthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire in_item_t in_item,
	output logic empty,
	input wire logic pop,
	output out_item_t out_item,
	input wire logic cfg_we,
	input wire logic [DepthW-1:0] cfg_data
);
	logic [DepthW-1:0] depth_q;
	logic q_valid, q_take;
	in_item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DepthW'(1);
		end else if (cfg_we) begin
			depth_q <= cfg_data;
		end
	end

	obds_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.q_valid, .q_item, .q_take
	);

	obds_back #(.MaxDepth(MaxDepth)) u_back (
		.clk, .arst_n, .depth_cfg(depth_q), .q_valid, .q_item, .q_take,
		.empty, .pop, .out_item
	);
endmodule
`default_nettype wire

// ===== hw/rtl/obds_front.sv =====
`default_nettype none
module obds_front import obds_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire in_item_t in_item,
	output logic q_valid,
	output in_item_t q_item,
	input wire logic q_take
);
	localparam int PtrW = $clog2(QueueDepth);
	in_item_t mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == (PtrW+1)'(QueueDepth));
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/obds_side.sv =====
`default_nettype none
module obds_side import obds_pkg::*; #(
	parameter int MaxDepth = MaxDepthDefault,
	parameter bit IsSell = 1'b0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic add,
	input wire logic [PriceW-1:0] price,
	input wire logic [VolInW-1:0] volume,
	input wire logic clear,
	input wire logic [$clog2(MaxDepth+1)-1:0] rd_idx,
	output logic [$clog2(MaxDepth+1)-1:0] count,
	output logic [PriceW-1:0] rd_price,
	output logic [VolW-1:0] rd_volume
);
	localparam int CntW = $clog2(MaxDepth+1);
	logic [PriceW-1:0] pr_q [MaxDepth];
	logic [VolW-1:0] vol_q [MaxDepth];
	logic [MaxDepth-1:0] valid_q;
	logic [MaxDepth-1:0] better, match;
	logic [MaxDepth:0] better_up;
	logic [VolW:0] sum [MaxDepth];
	logic any_match;

	assign count = CntW'($countones(valid_q));
	assign any_match = |match;
	assign better_up = {better, 1'b1};

	always_comb begin
		for (int i = 0; i < MaxDepth; i++) begin
			better[i] = valid_q[i] && (IsSell ? (pr_q[i] < price) : (pr_q[i] > price));
			match[i] = valid_q[i] && (pr_q[i] == price);
			sum[i] = {1'b0, vol_q[i]} + {(VolW+1-VolInW)'(0), volume};
		end
	end

	always_ff @(posedge clk) begin
		if (add) begin
			for (int i = 0; i < MaxDepth; i++) begin
				if (any_match) begin
					if (match[i]) begin
						vol_q[i] <= sum[i][VolW] ? '1 : sum[i][VolW-1:0];
					end
				end else if (!better[i]) begin
					if (better_up[i]) begin
						pr_q[i] <= price;
						vol_q[i] <= VolW'(volume);
					end else begin
						pr_q[i] <= pr_q[(i == 0) ? 0 : i-1];
						vol_q[i] <= vol_q[(i == 0) ? 0 : i-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (add && !any_match && !better[MaxDepth-1]) begin
			valid_q <= MaxDepth'({valid_q, 1'b1});
		end
	end

	always_comb begin
		rd_price = pr_q[rd_idx[$clog2(MaxDepth > 1 ? MaxDepth : 2)-1:0]];
		rd_volume = vol_q[rd_idx[$clog2(MaxDepth > 1 ? MaxDepth : 2)-1:0]];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/obds_back.sv =====
`default_nettype none
module obds_back import obds_pkg::*; #(
	parameter int MaxDepth = MaxDepthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [DepthW-1:0] depth_cfg,
	input wire logic q_valid,
	input wire in_item_t q_item,
	output logic q_take,
	output logic empty,
	input wire logic pop,
	output out_item_t out_item
);
	localparam int CntW = $clog2(MaxDepth+1);
	typedef enum logic [2:0] {
		ST_ADD = 3'b001,
		ST_SETUP = 3'b010,
		ST_DUMP = 3'b100
	} state_t;

	state_t state_q;
	logic [CntW-1:0] kb_q, idx_q;
	logic sell_ph_q;
	logic out_v_q;
	out_item_t out_q;
	logic [CntW-1:0] s_cnt, b_cnt, s_cnt_a, b_cnt_a, rd_s, rd_b, dlim;
	logic [PriceW-1:0] s_pr, b_pr;
	logic [VolW-1:0] s_vol, b_vol;
	logic add_s, add_b, clr, slot_free, emit_last, snap_empty;

	assign slot_free = !out_v_q || pop;
	assign q_take = (state_q == ST_ADD) && q_valid;
	assign add_s = q_take && q_item.is_sell;
	assign add_b = q_take && !q_item.is_sell;
	assign dlim = (depth_cfg > DepthW'(MaxDepth)) ? CntW'(MaxDepth) : CntW'(depth_cfg);
	assign empty = !out_v_q;
	assign out_item = out_q;
	assign rd_s = idx_q;
	assign rd_b = idx_q;

	obds_side #(.MaxDepth(MaxDepth), .IsSell(1'b1)) u_sell (
		.clk, .arst_n, .add(add_s), .price(q_item.price), .volume(q_item.volume),
		.clear(clr), .rd_idx(rd_s), .count(s_cnt), .rd_price(s_pr), .rd_volume(s_vol)
	);
	obds_side #(.MaxDepth(MaxDepth), .IsSell(1'b0)) u_buy (
		.clk, .arst_n, .add(add_b), .price(q_item.price), .volume(q_item.volume),
		.clear(clr), .rd_idx(rd_b), .count(b_cnt), .rd_price(b_pr), .rd_volume(b_vol)
	);

	assign s_cnt_a = (s_cnt < dlim) ? s_cnt : dlim;
	assign b_cnt_a = (b_cnt < dlim) ? b_cnt : dlim;
	assign snap_empty = (s_cnt_a == '0) && (b_cnt_a == '0);
	assign emit_last = sell_ph_q ? (idx_q == '0 && kb_q == '0)
		: (idx_q + CntW'(1) == kb_q);
	assign clr = ((state_q == ST_DUMP) && slot_free && emit_last)
		|| ((state_q == ST_SETUP) && snap_empty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ADD;
			out_v_q <= 1'b0;
			kb_q <= '0;
			idx_q <= '0;
			sell_ph_q <= 1'b0;
		end else begin
			if (pop) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_ADD: begin
					if (q_take && q_item.final_order) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					kb_q <= b_cnt_a;
					sell_ph_q <= (s_cnt_a != '0);
					idx_q <= (s_cnt_a != '0) ? s_cnt_a - CntW'(1) : '0;
					state_q <= snap_empty ? ST_ADD : ST_DUMP;
				end
				ST_DUMP: begin
					if (slot_free) begin
						out_v_q <= 1'b1;
						if (emit_last) begin
							state_q <= ST_ADD;
						end else if (sell_ph_q && idx_q == '0) begin
							sell_ph_q <= 1'b0;
						end else if (sell_ph_q) begin
							idx_q <= idx_q - CntW'(1);
						end else begin
							idx_q <= idx_q + CntW'(1);
						end
					end
				end
				default: state_q <= ST_ADD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DUMP && slot_free) begin
			out_q.out_is_sell <= sell_ph_q;
			out_q.level_price <= sell_ph_q ? s_pr : b_pr;
			out_q.level_volume <= sell_ph_q ? s_vol : b_vol;
			out_q.last_level <= emit_last;
		end
	end
endmodule
`default_nettype wire
